>>> hw/rtl/qn_pkg.sv
// Shared widths, types and constants for the quaternion normalizer.
package qn_pkg;

    // Component and result widths
    localparam int CW    = 16;          // input component, signed Q4.12
    localparam int OW    = 16;          // result component, signed Q1.14
    localparam int SQW   = 31;          // one square, at most 2^30
    localparam int SW    = 33;          // sum of four squares, at most 2^32
    localparam int NBIT  = 15;          // result magnitude bits, 0..16384
    localparam int NSTEP = 2 * NBIT;    // two stages per result bit
    localparam int RSH   = 30;          // target scale: mag^2 * 2^30
    localparam int EW    = 1 + SQW + RSH; // signed remainder
    localparam int WW    = 50;          // signed (2n-1)*S running term
    localparam int XW    = 66;          // signed trial difference

    localparam logic [NBIT-1:0] UNIT_ONE = 15'd16384;

    typedef logic signed [CW-1:0]   comp_t;
    typedef logic signed [OW-1:0]   unit_t;
    typedef logic        [SQW-1:0]  sq_t;
    typedef logic        [SW-1:0]   sum_t;
    typedef logic        [NBIT-1:0] mag_t;
    typedef logic signed [EW-1:0]   err_t;
    typedef logic signed [WW-1:0]   acc_t;

    // One normalized quaternion as it leaves the block
    typedef struct packed {
        logic  zero;
        unit_t z;
        unit_t y;
        unit_t x;
        unit_t w;
    } res_t;

endpackage

>>> hw/rtl/qn_lane.sv
// One component lane: bit-by-bit search of round(mag * 16384 / sqrt(S)).
module qn_lane
    import qn_pkg::*;
(
    input  logic aclk,
    input  logic en,
    input  sq_t  sq_in,
    input  sum_t sum_in,
    input  sum_t sum_stg [0:NSTEP-1],
    output mag_t mag_out
);

    // Stage 2j holds the state before bit j, stage 2j+1 adds the trial term.
    // e: mag^2*2^30 - (2n-1)^2*S,  w: (2n-1)*S,  n: accepted bits so far
    err_t e_reg [0:NSTEP-1];
    acc_t w_reg [0:NSTEP-1];
    mag_t n_reg [0:NSTEP];
    acc_t d_reg [0:NBIT-1];

    // Initial remainder with n = 0
    always_ff @(posedge aclk) begin
        if (en) begin
            e_reg[0] <= err_t'({1'b0, sq_in, {RSH{1'b0}}})
                      - err_t'({{(EW-SW){1'b0}}, sum_in});
            w_reg[0] <= -acc_t'({{(WW-SW){1'b0}}, sum_in});
            n_reg[0] <= '0;
        end
    end

    for (genvar j = 0; j < NBIT; j++) begin : g_bit
        localparam int K  = NBIT - 1 - j;
        localparam int SA = 2 * j;
        localparam int SB = 2 * j + 1;

        acc_t                d_next;
        logic signed [XW-1:0] diff;
        mag_t                cand;
        logic                take;

        // Trial term (2n + b - 1) * S
        always_comb begin
            d_next = w_reg[SA] + (acc_t'({{(WW-SW){1'b0}}, sum_stg[SA]}) << K);
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                d_reg[j]  <= d_next;
                e_reg[SB] <= e_reg[SA];
                w_reg[SB] <= w_reg[SA];
                n_reg[SB] <= n_reg[SA];
            end
        end

        // Keep the bit when (2(n+b)-1)^2 * S still fits under the target
        always_comb begin
            diff   = XW'(e_reg[SB]) - (XW'(d_reg[j]) << (K + 2));
            cand   = n_reg[SB] | (mag_t'(1) << K);
            take   = !diff[XW-1] && (cand <= UNIT_ONE);
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[SB+1] <= take ? cand : n_reg[SB];
            end
        end

        if (j < NBIT - 1) begin : g_fwd
            acc_t w_step;

            // Running (2n-1)*S after the bit is kept
            always_comb begin
                w_step = w_reg[SB] + (acc_t'({{(WW-SW){1'b0}}, sum_stg[SB]}) << (K + 1));
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    e_reg[SB+1] <= take ? err_t'(diff[EW-1:0]) : e_reg[SB];
                    w_reg[SB+1] <= take ? w_step : w_reg[SB];
                end
            end
        end
    end

    assign mag_out = n_reg[NSTEP];

endmodule

>>> hw/rtl/quaternion_normalize.sv
// Top level of the quaternion normalizer: squares, sum, four search lanes, output buffer.
//
//  channel  | dir | tdata (low bit up)                | tuser
//  s_       | in  | comp_w, comp_x, comp_y, comp_z    | -
//  m_       | out | unit_w, unit_x, unit_y, unit_z    | zero_length
//
// One request per cycle while the output buffer has room. The depth is
// set by the 15 result bits, each a 66-bit trial subtract split over two
// stages, behind square and sum stages.
// Reset is synchronous and clears the valid bits and the buffer count only.
// The pipeline moves as a whole while the two-entry output buffer has room,
// so s_tready comes from registers; one waiting result does not block input,
// a full buffer holds the pipeline and drops s_tready.
module quaternion_normalize
    import qn_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // comp_w, comp_x, comp_y, comp_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // unit_w, unit_x, unit_y, unit_z
    output logic        m_tuser    // zero_length
);

    localparam int LANE0 = 3;
    localparam int LANEN = LANE0 + NSTEP;
    localparam int FIN   = LANEN + 1;

    logic en;
    logic push;
    logic pop;

    logic  vld_reg [0:FIN];
    comp_t comp_reg [0:3];
    sq_t   sq_reg [0:3];
    sq_t   sq2_reg [0:3];
    sum_t  sum_reg;
    sum_t  lane_sum_reg [0:NSTEP-1];
    logic [3:0] neg_reg [1:LANEN];
    logic       zero_reg [2:LANEN];
    mag_t  lane_mag [0:3];
    res_t  res_reg;

    res_t       buf0_reg, buf0_next;
    res_t       buf1_reg, buf1_next;
    logic [1:0] cnt_reg, cnt_next;

    assign en       = (cnt_reg != 2'd2);
    assign s_tready = en;
    assign push     = vld_reg[FIN] && en;
    assign pop      = m_tvalid && m_tready;

    // Valid bits move with the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= FIN; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i <= FIN; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Input register, squares, sum
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                comp_reg[i]    <= comp_t'(s_tdata[i*CW +: CW]);
                sq_reg[i]      <= sq_t'(32'(comp_reg[i] * comp_reg[i]));
                sq2_reg[i]     <= sq_reg[i];
            end
            sum_reg     <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]) + SW'(sq_reg[3]);
        end
    end

    // Side pipelines for the sum, signs and zero flag
    always_ff @(posedge aclk) begin
        if (en) begin
            neg_reg[1]  <= {comp_reg[3][CW-1], comp_reg[2][CW-1],
                            comp_reg[1][CW-1], comp_reg[0][CW-1]};
            neg_reg[2]  <= neg_reg[1];
            zero_reg[2] <= (sq_reg[0] == '0) && (sq_reg[1] == '0)
                        && (sq_reg[2] == '0) && (sq_reg[3] == '0);
            lane_sum_reg[0] <= sum_reg;
            for (int t = 1; t < NSTEP; t++) begin
                lane_sum_reg[t] <= lane_sum_reg[t-1];
            end
            for (int i = LANE0; i <= LANEN; i++) begin
                neg_reg[i]  <= neg_reg[i-1];
                zero_reg[i] <= zero_reg[i-1];
            end
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        qn_lane u_lane (
            .aclk    (aclk),
            .en      (en),
            .sq_in   (sq2_reg[g]),
            .sum_in  (sum_reg),
            .sum_stg (lane_sum_reg),
            .mag_out (lane_mag[g])
        );
    end

    // Apply signs, force zero for a zero-length input
    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg.zero <= zero_reg[LANEN];
            res_reg.w <= zero_reg[LANEN] ? '0 : (neg_reg[LANEN][0]
                ? -unit_t'({1'b0, lane_mag[0]}) : unit_t'({1'b0, lane_mag[0]}));
            res_reg.x <= zero_reg[LANEN] ? '0 : (neg_reg[LANEN][1]
                ? -unit_t'({1'b0, lane_mag[1]}) : unit_t'({1'b0, lane_mag[1]}));
            res_reg.y <= zero_reg[LANEN] ? '0 : (neg_reg[LANEN][2]
                ? -unit_t'({1'b0, lane_mag[2]}) : unit_t'({1'b0, lane_mag[2]}));
            res_reg.z <= zero_reg[LANEN] ? '0 : (neg_reg[LANEN][3]
                ? -unit_t'({1'b0, lane_mag[3]}) : unit_t'({1'b0, lane_mag[3]}));
        end
    end

    // Two-entry output buffer
    always_comb begin
        buf0_next = buf0_reg;
        buf1_next = buf1_reg;
        cnt_next  = cnt_reg;
        case (cnt_reg)
            2'd0: begin
                if (push) begin
                    buf0_next = res_reg;
                    cnt_next  = 2'd1;
                end
            end
            2'd1: begin
                if (push && pop) begin
                    buf0_next = res_reg;
                end else if (push) begin
                    buf1_next = res_reg;
                    cnt_next  = 2'd2;
                end else if (pop) begin
                    cnt_next  = 2'd0;
                end
            end
            2'd2: begin
                if (pop) begin
                    buf0_next = buf1_reg;
                    cnt_next  = 2'd1;
                end
            end
            default: begin
                cnt_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        buf0_reg <= buf0_next;
        buf1_reg <= buf1_next;
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {buf0_reg.z, buf0_reg.y, buf0_reg.x, buf0_reg.w};
    assign m_tuser  = buf0_reg.zero;

`ifndef SYNTHESIS
    // A zero-length result carries all-zero components
    a_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("zero-length result with nonzero components");

    // Every component stays within plus or minus one
    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |->
            $signed(m_tdata[15:0])  <= 16'sd16384 && $signed(m_tdata[15:0])  >= -16'sd16384 &&
            $signed(m_tdata[31:16]) <= 16'sd16384 && $signed(m_tdata[31:16]) >= -16'sd16384 &&
            $signed(m_tdata[47:32]) <= 16'sd16384 && $signed(m_tdata[47:32]) >= -16'sd16384 &&
            $signed(m_tdata[63:48]) <= 16'sd16384 && $signed(m_tdata[63:48]) >= -16'sd16384)
        else $error("normalized component out of range");

    // The largest component of a nonzero quaternion is at least one half
    a_half_min: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[LANEN] && !zero_reg[LANEN] |->
            (lane_mag[0][14] || lane_mag[0][13] || lane_mag[1][14] || lane_mag[1][13] ||
             lane_mag[2][14] || lane_mag[2][13] || lane_mag[3][14] || lane_mag[3][13]))
        else $error("no component reaches one half");

    // A finished result held by a stall is neither lost nor changed
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[FIN] && !en |=> vld_reg[FIN] && $stable(res_reg))
        else $error("stalled result changed");
`endif

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the quaternion normalizer stream block.
`timescale 1ns / 1ps

module testbench;
    import qn_pkg::*;

    // Normalized-quaternion scoreboard: predicts each result and checks it in order
    class qn_checker;
        res_t unit_queue[$];
        int   errors;
        int   checked;
        int   zero_hits;

        function new();
            errors    = 0;
            checked   = 0;
            zero_hits = 0;
        endfunction

        // Round-half-up of |c| * 16384 / sqrt(sumsq), found bit by bit
        function unit_t norm_component(comp_t c, logic [63:0] sumsq);
            longint      cl;
            logic [63:0] mag;
            logic [63:0] lim;
            logic [63:0] n;
            logic [63:0] cand;
            logic [63:0] t;
            cl  = c;
            mag = (cl < 0) ? -cl : cl;
            lim = (mag * mag) << RSH;
            n   = 0;
            for (int b = NBIT - 1; b >= 0; b--) begin
                cand = n | (64'd1 << b);
                if (cand <= UNIT_ONE) begin
                    t = 2 * cand - 1;
                    if (t * t * sumsq <= lim)
                        n = cand;
                end
            end
            return (cl < 0) ? unit_t'(-n) : unit_t'(n);
        endfunction

        // Accepted request: work out the unit quaternion it must produce
        function void note_request(comp_t w, comp_t x, comp_t y, comp_t z);
            longint      lw;
            longint      lx;
            longint      ly;
            longint      lz;
            logic [63:0] sumsq;
            res_t        exp_res;
            lw    = w;
            lx    = x;
            ly    = y;
            lz    = z;
            sumsq = lw * lw + lx * lx + ly * ly + lz * lz;
            if (sumsq == 0) begin
                exp_res = '0;
                exp_res.zero = 1'b1;
            end else begin
                exp_res.zero = 1'b0;
                exp_res.w = norm_component(w, sumsq);
                exp_res.x = norm_component(x, sumsq);
                exp_res.y = norm_component(y, sumsq);
                exp_res.z = norm_component(z, sumsq);
            end
            unit_queue.push_back(exp_res);
        endfunction

        task flag_mismatch(string what, int got, int want);
            $display("ERROR @%0t: %s got %0d expected %0d", $time, what, got, want);
            errors++;
        endtask

        // Compare one delivered result against the oldest prediction
        task check_result(res_t got);
            res_t want;
            if (unit_queue.size() == 0) begin
                flag_mismatch("unexpected result, zero_length", got.zero, 0);
            end else begin
                want = unit_queue.pop_front();
                checked++;
                if (want.zero)
                    zero_hits++;
                if (got.w !== want.w)
                    flag_mismatch("unit_w", got.w, want.w);
                if (got.x !== want.x)
                    flag_mismatch("unit_x", got.x, want.x);
                if (got.y !== want.y)
                    flag_mismatch("unit_y", got.y, want.y);
                if (got.z !== want.z)
                    flag_mismatch("unit_z", got.z, want.z);
                if (got.zero !== want.zero)
                    flag_mismatch("zero_length", got.zero, want.zero);
            end
        endtask
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;

    int idle_pct  = 0;
    int stall_pct = 0;

    qn_checker chk = new();

    quaternion_normalize uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    // Result side: check accepted results, stall at random
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            chk.check_result({m_tuser, m_tdata});
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Offer one quaternion, with an optional random gap first; returns once taken
    task send_quat(input comp_t w, input comp_t x, input comp_t y, input comp_t z);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom};
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x, w};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        chk.note_request(w, x, y, z);
    endtask

    function comp_t small_comp();
        int v;
        v = $urandom_range(32);
        return comp_t'(v - 16);
    endfunction

    // Random quaternion of one of several shapes
    task send_random();
        int    kind;
        comp_t c[4];
        kind = $urandom_range(9);
        for (int i = 0; i < 4; i++)
            c[i] = (kind <= 3) ? comp_t'($urandom) : small_comp();
        case (kind)
            6, 7: begin
                c[$urandom_range(3)] = comp_t'($urandom);
            end
            8: begin
                c = '{default: '0};
                c[$urandom_range(3)] = comp_t'($urandom);
            end
            9: begin
                if ($urandom_range(3) == 0)
                    c = '{default: '0};
            end
            default: ;
        endcase
        send_quat(c[0], c[1], c[2], c[3]);
    endtask

    task send_directed();
        send_quat(0, 0, 0, 0);
        send_quat(-32768, -32768, -32768, -32768);
        send_quat(32767, 32767, 32767, 32767);
        send_quat(-32768, 0, 0, 0);
        send_quat(0, 32767, 0, 0);
        send_quat(0, 0, -32768, 0);
        send_quat(0, 0, 0, 32767);
        send_quat(1, 0, 0, 0);
        send_quat(0, -1, 0, 0);
        send_quat(0, 0, 1, 0);
        send_quat(0, 0, 0, -1);
        send_quat(4096, 0, 0, 0);
        send_quat(3, 4, 0, 0);
        send_quat(-3, 0, -4, 0);
        send_quat(1, 1, 1, 1);
        send_quat(-1, 1, -1, 1);
        send_quat(32767, -32768, 1, -1);
        send_quat(4096, 4096, 4096, 4096);
        send_quat(0, 0, 0, 0);
        send_quat(-32768, 32767, -32768, 32767);
    endtask

    task wait_drained();
        while (chk.unit_queue.size() != 0)
            @(posedge aclk);
    endtask

    // Phases: free flow, sparse input, heavy output stall, both
    initial begin
        int idle_set[4];
        int stall_set[4];
        idle_set  = '{0, 85, 0, 34};
        stall_set = '{0, 0, 85, 34};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = idle_set[ph];
            stall_pct = stall_set[ph];
            if (ph == 0)
                send_directed();
            repeat (245) send_random();
            s_tvalid <= 1'b0;
            wait_drained();
        end
        repeat (60) @(posedge aclk);
        $display("Checked %0d normalized quaternions, %0d of zero length,", chk.checked,
                 chk.zero_hits);
        $display("over free-flowing, sparse-input, stalled-output and mixed pacing.");
        if (chk.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog
    initial begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
